/* rtl/vgaio_pkg.sv */
// ============================================================================
// VGA I/O register file package
// Types and fixed constants shared by the VGA I/O register file: port codes,
// register file layout inside the index/data memory, and reset values.
// ============================================================================
package vgaio_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        SRC_DIRECT,
        SRC_REGFILE,
        SRC_PALETTE
    } rd_src_t;

    localparam logic REQ_WRITE = 1'b1;

    // Palette pointers are always ten bits wide, whatever the store depth.
    localparam int PTR_W = 10;

    // Index/data register memory: four register groups packed into 64 bytes.
    localparam int RF_AW = 6;
    localparam logic [RF_AW-1:0] CRTC_BASE = 6'd0;
    localparam logic [RF_AW-1:0] ATTR_BASE = 6'd25;
    localparam logic [RF_AW-1:0] SEQ_BASE  = 6'd46;
    localparam logic [RF_AW-1:0] GFX_BASE  = 6'd51;

    localparam int SEQ_IDX_W  = 3;
    localparam int CRTC_IDX_W = 5;
    localparam int GFX_IDX_W  = 4;
    localparam int ATTR_IDX_W = 5;

    localparam logic [7:0] SEQ_MAX_IDX  = 8'd4;
    localparam logic [7:0] CRTC_MAX_IDX = 8'h18;
    localparam logic [7:0] GFX_MAX_IDX  = 8'd8;
    localparam logic [7:0] ATTR_MAX_IDX = 8'd20;

    // I/O port codes.
    localparam logic [15:0] PORT_ATTR_ADDR  = 16'h03C0;
    localparam logic [15:0] PORT_ATTR_DATA  = 16'h03C1;
    localparam logic [15:0] PORT_MISC_W     = 16'h03C2;
    localparam logic [15:0] PORT_SEQ_ADDR   = 16'h03C4;
    localparam logic [15:0] PORT_SEQ_DATA   = 16'h03C5;
    localparam logic [15:0] PORT_DAC_MASK   = 16'h03C6;
    localparam logic [15:0] PORT_DAC_RADDR  = 16'h03C7;
    localparam logic [15:0] PORT_DAC_WADDR  = 16'h03C8;
    localparam logic [15:0] PORT_DAC_DATA   = 16'h03C9;
    localparam logic [15:0] PORT_FEAT_R     = 16'h03CA;
    localparam logic [15:0] PORT_MISC_R     = 16'h03CC;
    localparam logic [15:0] PORT_GFX_ADDR   = 16'h03CE;
    localparam logic [15:0] PORT_GFX_DATA   = 16'h03CF;
    localparam logic [15:0] PORT_CRTC_ADDR  = 16'h03D4;
    localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;
    localparam logic [15:0] PORT_STATUS1    = 16'h03DA;

    // Reset and read-back values.
    localparam logic [7:0] MISC_RESET       = 8'hC3;
    localparam logic [7:0] SENSE_LIMIT      = 8'h1C;
    localparam logic [7:0] SENSE_BIT        = 8'h10;
    localparam logic [7:0] RETRACE_BIT      = 8'h80;
    localparam logic [7:0] STATUS_RETRACE   = 8'h09;
    localparam logic [7:0] STATUS_VRETRACE  = 8'h01;
    localparam logic [7:0] DAC_STATE_WRITE  = 8'h03;
    localparam logic [7:0] SEQ0_FORCE_BITS  = 8'h03;

endpackage

/* rtl/vga_io_register_file.sv */
// ============================================================================
// VGA I/O register file
// Byte-wide port model of the VGA register set: misc/feature registers,
// sequencer, CRTC, graphics and attribute index/data pairs, and the DAC.
// ============================================================================
//
// The block takes one port request at a time and returns exactly one response
// (read byte plus an unmapped flag) for each. The request is captured at the
// accepting edge. A byte access is decoded, and the register memories are
// accessed, in the execute state; the response register is then loaded from
// the synchronous memory read data in the response state, which waits while
// the previous response is still held at the output. The block is ready again
// in the same cycle that the response becomes valid. A word write goes through
// the decode step twice, since its second byte goes to port+1 as a separate
// byte write. The indexed sequencer, CRTC, graphics and attribute registers
// live in one 64-byte memory, and the palette bytes in a memory of PALETTE_DEPTH
// bytes; both have a registered read, which data-port reads go through.
// Palette bytes 0 to 2 are also shadowed in flops so that the monitor sense bit
// of the input status port is available without a memory read. After reset the
// block sweeps both memories to zero, one address per cycle, over all
// PALETTE_DEPTH palette addresses; no request is accepted during that sweep.
// A finished response waits in its output register while the next request is
// accepted and decoded.
//
module vga_io_register_file #(
    parameter int PALETTE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [15:0] port,
    input  logic [15:0] wdata,
    input  logic        word_access,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [7:0]  rdata,
    output logic        unmapped
);
    import vgaio_pkg::*;

    localparam int PAW      = $clog2(PALETTE_DEPTH);
    localparam int RF_DEPTH = 1 << RF_AW;

    // Next palette pointer: wraps at 1024 and again at the store depth.
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = p + 1'b1;
        return ({1'b0, n} >= (PTR_W + 1)'(PALETTE_DEPTH)) ? '0 : n;
    endfunction

    function automatic logic ptr_in_store(input logic [PTR_W-1:0] p);
        return {1'b0, p} < (PTR_W + 1)'(PALETTE_DEPTH);
    endfunction

    // Control state.
    state_t                 state_reg, state_next;
    logic                   byte_sel_reg, byte_sel_next;
    logic [PAW-1:0]         clr_cnt_reg, clr_cnt_next;

    // Captured request.
    logic                   typ_reg;
    logic [15:0]            port_reg;
    logic [15:0]            wdata_reg;
    logic                   word_reg;

    // Architectural registers held in flops.
    logic [7:0]             misc_reg, misc_next;
    logic [7:0]             feat_reg, feat_next;
    logic [SEQ_IDX_W-1:0]   seq_idx_reg, seq_idx_next;
    logic [CRTC_IDX_W-1:0]  crtc_idx_reg, crtc_idx_next;
    logic [GFX_IDX_W-1:0]   gfx_idx_reg, gfx_idx_next;
    logic [ATTR_IDX_W-1:0]  attr_idx_reg, attr_idx_next;
    logic                   attr_flip_reg, attr_flip_next;
    logic [7:0]             dac_mask_reg, dac_mask_next;
    logic                   dac_wmode_reg, dac_wmode_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [1:0]             tick_reg, tick_next;
    logic [7:0]             pal0_reg, pal0_next;
    logic [7:0]             pal1_reg, pal1_next;
    logic [7:0]             pal2_reg, pal2_next;

    // Response assembly.
    logic                   bad_reg, bad_next;
    logic [7:0]             val_reg, val_next;
    rd_src_t                src_reg, src_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [7:0]             rdata_reg, rdata_next;
    logic                   unmapped_reg, unmapped_next;

    // Memory ports.
    logic [7:0]             pal_mem [PALETTE_DEPTH];
    logic                   pal_we;
    logic [PAW-1:0]         pal_waddr;
    logic [7:0]             pal_wdata;
    logic                   pal_re;
    logic [PAW-1:0]         pal_raddr;
    logic [7:0]             pal_dout_reg;

    logic [7:0]             rf_mem [RF_DEPTH];
    logic                   rf_we;
    logic [RF_AW-1:0]       rf_waddr;
    logic [7:0]             rf_wdata;
    logic                   rf_re;
    logic [RF_AW-1:0]       rf_raddr;
    logic [7:0]             rf_dout_reg;

    // Byte currently being decoded.
    logic [15:0]            cur_port;
    logic [7:0]             cur_data;
    logic                   cur_flag;
    logic                   word_more;
    logic                   out_free;
    logic                   sense_ok;
    logic [1:0]             tick_inc;

    assign cur_port  = byte_sel_reg ? (port_reg + 16'd1) : port_reg;
    assign cur_data  = byte_sel_reg ? wdata_reg[15:8] : wdata_reg[7:0];
    assign word_more = (typ_reg == REQ_WRITE) && word_reg && !byte_sel_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign sense_ok  = (pal0_reg <= SENSE_LIMIT) && (pal1_reg <= SENSE_LIMIT)
                       && (pal2_reg <= SENSE_LIMIT);
    assign tick_inc  = tick_reg + 2'd1;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rdata     = rdata_reg;
    assign unmapped  = unmapped_reg;

    // ------------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == PAW'(PALETTE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!word_more)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and memory control.
    // ------------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        byte_sel_next  = byte_sel_reg;
        misc_next      = misc_reg;
        feat_next      = feat_reg;
        seq_idx_next   = seq_idx_reg;
        crtc_idx_next  = crtc_idx_reg;
        gfx_idx_next   = gfx_idx_reg;
        attr_idx_next  = attr_idx_reg;
        attr_flip_next = attr_flip_reg;
        dac_mask_next  = dac_mask_reg;
        dac_wmode_next = dac_wmode_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        tick_next      = tick_reg;
        pal0_next      = pal0_reg;
        pal1_next      = pal1_reg;
        pal2_next      = pal2_reg;
        bad_next       = bad_reg;
        val_next       = val_reg;
        src_next       = src_reg;
        rsp_valid_next = rsp_valid_reg;
        rdata_next     = rdata_reg;
        unmapped_next  = unmapped_reg;
        cur_flag       = 1'b0;

        pal_we    = 1'b0;
        pal_waddr = wr_ptr_reg[PAW-1:0];
        pal_wdata = cur_data;
        pal_re    = 1'b0;
        pal_raddr = rd_ptr_reg[PAW-1:0];
        rf_we     = 1'b0;
        rf_waddr  = '0;
        rf_wdata  = cur_data;
        rf_re     = 1'b0;
        rf_raddr  = '0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero both memories; the register memory is covered by the
                // first RF_DEPTH addresses of the sweep.
                pal_we       = 1'b1;
                pal_waddr    = clr_cnt_reg;
                pal_wdata    = '0;
                rf_we        = (clr_cnt_reg >> RF_AW) == '0;
                rf_waddr     = clr_cnt_reg[RF_AW-1:0];
                rf_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                byte_sel_next = 1'b0;
            end
            ST_EXEC:
            begin
                if (typ_reg == REQ_WRITE)
                begin
                    unique case (cur_port)
                        PORT_MISC_W:    misc_next = cur_data;
                        PORT_STATUS1:   feat_next = cur_data;
                        PORT_DAC_MASK:  dac_mask_next = cur_data;
                        PORT_SEQ_ADDR:
                            seq_idx_next = (cur_data > SEQ_MAX_IDX) ? '0
                                           : cur_data[SEQ_IDX_W-1:0];
                        PORT_SEQ_DATA:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = SEQ_BASE + RF_AW'(seq_idx_reg);
                            // Sequencer reset register keeps both reset bits set.
                            if (seq_idx_reg == '0)
                                rf_wdata = cur_data | SEQ0_FORCE_BITS;
                        end
                        PORT_CRTC_ADDR:
                            crtc_idx_next = (cur_data > CRTC_MAX_IDX) ? '0
                                            : cur_data[CRTC_IDX_W-1:0];
                        PORT_CRTC_DATA:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = CRTC_BASE + RF_AW'(crtc_idx_reg);
                        end
                        PORT_GFX_ADDR:
                            gfx_idx_next = (cur_data > GFX_MAX_IDX) ? '0
                                           : cur_data[GFX_IDX_W-1:0];
                        PORT_GFX_DATA:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = GFX_BASE + RF_AW'(gfx_idx_reg);
                        end
                        PORT_ATTR_ADDR:
                        begin
                            if (!attr_flip_reg)
                                attr_idx_next = (cur_data > ATTR_MAX_IDX) ? '0
                                                : cur_data[ATTR_IDX_W-1:0];
                            else
                            begin
                                rf_we    = 1'b1;
                                rf_waddr = ATTR_BASE + RF_AW'(attr_idx_reg);
                            end
                            attr_flip_next = !attr_flip_reg;
                        end
                        PORT_DAC_RADDR:
                        begin
                            rd_ptr_next    = PTR_W'(cur_data);
                            dac_wmode_next = 1'b0;
                        end
                        PORT_DAC_WADDR:
                        begin
                            wr_ptr_next    = PTR_W'(cur_data);
                            dac_wmode_next = 1'b1;
                        end
                        PORT_DAC_DATA:
                        begin
                            if (ptr_in_store(wr_ptr_reg))
                            begin
                                pal_we = 1'b1;
                                if (wr_ptr_reg == PTR_W'(0))
                                    pal0_next = cur_data;
                                if (wr_ptr_reg == PTR_W'(1))
                                    pal1_next = cur_data;
                                if (wr_ptr_reg == PTR_W'(2))
                                    pal2_next = cur_data;
                            end
                            wr_ptr_next = ptr_adv(wr_ptr_reg);
                        end
                        default:        cur_flag = 1'b1;
                    endcase
                    val_next = '0;
                    src_next = SRC_DIRECT;
                end
                else
                begin
                    val_next = '0;
                    src_next = SRC_DIRECT;
                    unique case (cur_port)
                        PORT_STATUS1:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc[0])
                                val_next = STATUS_RETRACE;
                            else if (tick_inc == 2'd0)
                                val_next = STATUS_VRETRACE;
                            attr_flip_next = 1'b0;
                        end
                        PORT_MISC_R:    val_next = misc_reg;
                        PORT_FEAT_R:    val_next = feat_reg;
                        PORT_MISC_W:
                        begin
                            // Input status 0: monitor sense and retrace bit.
                            val_next  = (sense_ok ? SENSE_BIT : 8'h00)
                                        | (tick_reg[0] ? RETRACE_BIT : 8'h00);
                            tick_next = tick_inc;
                        end
                        PORT_SEQ_ADDR:  val_next = 8'(seq_idx_reg);
                        PORT_CRTC_ADDR: val_next = 8'(crtc_idx_reg);
                        PORT_GFX_ADDR:  val_next = 8'(gfx_idx_reg);
                        PORT_SEQ_DATA:
                        begin
                            rf_re    = 1'b1;
                            rf_raddr = SEQ_BASE + RF_AW'(seq_idx_reg);
                            src_next = SRC_REGFILE;
                        end
                        PORT_CRTC_DATA:
                        begin
                            rf_re    = 1'b1;
                            rf_raddr = CRTC_BASE + RF_AW'(crtc_idx_reg);
                            src_next = SRC_REGFILE;
                        end
                        PORT_GFX_DATA:
                        begin
                            rf_re    = 1'b1;
                            rf_raddr = GFX_BASE + RF_AW'(gfx_idx_reg);
                            src_next = SRC_REGFILE;
                        end
                        PORT_ATTR_DATA:
                        begin
                            rf_re    = 1'b1;
                            rf_raddr = ATTR_BASE + RF_AW'(attr_idx_reg);
                            src_next = SRC_REGFILE;
                        end
                        PORT_DAC_MASK:  val_next = dac_mask_reg;
                        PORT_DAC_RADDR:
                            val_next = dac_wmode_reg ? DAC_STATE_WRITE : 8'h00;
                        PORT_DAC_WADDR:
                        begin
                            val_next       = wr_ptr_reg[7:0];
                            dac_wmode_next = 1'b1;
                        end
                        PORT_DAC_DATA:
                        begin
                            if (ptr_in_store(rd_ptr_reg))
                            begin
                                pal_re   = 1'b1;
                                src_next = SRC_PALETTE;
                            end
                            rd_ptr_next = ptr_adv(rd_ptr_reg);
                        end
                        default:        cur_flag = 1'b1;
                    endcase
                end

                bad_next = byte_sel_reg ? (bad_reg | cur_flag) : cur_flag;
                if (word_more)
                    byte_sel_next = 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    unmapped_next  = bad_reg;
                    unique case (src_reg)
                        SRC_REGFILE: rdata_next = rf_dout_reg;
                        SRC_PALETTE: rdata_next = pal_dout_reg;
                        default:     rdata_next = val_reg;
                    endcase
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control and architectural registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            byte_sel_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            misc_reg      <= MISC_RESET;
            feat_reg      <= '0;
            seq_idx_reg   <= '0;
            crtc_idx_reg  <= '0;
            gfx_idx_reg   <= '0;
            attr_idx_reg  <= '0;
            attr_flip_reg <= 1'b0;
            dac_mask_reg  <= '0;
            dac_wmode_reg <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            tick_reg      <= '0;
            pal0_reg      <= '0;
            pal1_reg      <= '0;
            pal2_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_sel_reg  <= byte_sel_next;
            clr_cnt_reg   <= clr_cnt_next;
            misc_reg      <= misc_next;
            feat_reg      <= feat_next;
            seq_idx_reg   <= seq_idx_next;
            crtc_idx_reg  <= crtc_idx_next;
            gfx_idx_reg   <= gfx_idx_next;
            attr_idx_reg  <= attr_idx_next;
            attr_flip_reg <= attr_flip_next;
            dac_mask_reg  <= dac_mask_next;
            dac_wmode_reg <= dac_wmode_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            tick_reg      <= tick_next;
            pal0_reg      <= pal0_next;
            pal1_reg      <= pal1_next;
            pal2_reg      <= pal2_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            typ_reg   <= req_type;
            port_reg  <= port;
            wdata_reg <= wdata;
            word_reg  <= word_access;
        end
        bad_reg      <= bad_next;
        val_reg      <= val_next;
        src_reg      <= src_next;
        rdata_reg    <= rdata_next;
        unmapped_reg <= unmapped_next;
    end

    // ------------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_waddr] <= pal_wdata;
        if (pal_re)
            pal_dout_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wdata;
        if (rf_re)
            rf_dout_reg <= rf_mem[rf_raddr];
    end

endmodule
